// ----- hw/rtl/lvsa_pkg.sv -----
// shared constants for the labeled voxel share accumulator
package lvsa_pkg;

  localparam int MAX_ATOMS_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 24;

  localparam int LABEL_W  = 13;
  localparam int ENERGY_W = 32;
  localparam int BIND_W   = 48;
  localparam int OUT_CNT_W = 24;
  localparam int ATOMS_W  = 13;

  // item function codes
  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // register byte addresses
  localparam logic [2:0] ADDR_ATOMS_IN_USE = 3'd0;
  localparam logic [2:0] ADDR_ISO_LEVEL    = 3'd4;

  // binding sum floor, -2^47
  localparam logic signed [BIND_W-1:0] BIND_MIN = {1'b1, {(BIND_W-1){1'b0}}};

endpackage

// ----- hw/rtl/labeled_voxel_share_accumulator.sv -----
// top level: per-atom voxel share accumulation table with read-and-clear
// result path: a read item passes the modify stage register, then strobes from the result register
// throughput: one item per cycle while busy is low; the share table is one ram, read at accept,
//   modified and written back the next cycle, with a one-entry forward path
// reset: busy stays high while every table entry is swept to zero
// results carry no back-pressure: each is on the ports for one cycle only
module labeled_voxel_share_accumulator
  import lvsa_pkg::*;
#(
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // item command
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic signed [LABEL_W-1:0]  atom_label,
  input  logic signed [ENERGY_W-1:0] energy,
  // result
  output logic                       result_strobe,
  output logic                       share_valid,
  output logic [OUT_CNT_W-1:0]       voxel_count,
  output logic [OUT_CNT_W-1:0]       void_count,
  output logic signed [BIND_W-1:0]   binding_sum,
  output logic signed [ENERGY_W-1:0] deepest_energy
);

  localparam int AW      = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int ENTRY_W = 2 * COUNT_BITS + BIND_W + ENERGY_W;
  localparam int CNT_X_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  // entry field positions, low to high: count, void, binding, deepest
  localparam int VOID_LO = COUNT_BITS;
  localparam int BIND_LO = 2 * COUNT_BITS;
  localparam int DEEP_LO = 2 * COUNT_BITS + BIND_W;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [ATOMS_W-1:0]         atoms_in_use;
  logic signed [ENERGY_W-1:0] iso_level;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // decode on the word index only, so every write lands in a defined slot
  always_ff @(posedge clk) begin
    if (rst) begin
      atoms_in_use <= '0;
      iso_level    <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_ISO_LEVEL[2]) begin
        iso_level <= pwdata;
      end else begin
        atoms_in_use <= pwdata[ATOMS_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_ISO_LEVEL[2]) begin
      prdata = iso_level;
    end else begin
      prdata = 32'(atoms_in_use);
    end
  end

  // ------------------------------------------------------------------
  // reset sweep: write zero into every entry before taking items
  // ------------------------------------------------------------------
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(MAX_ATOMS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign busy = clr_active;

  // ------------------------------------------------------------------
  // accept stage: label check and ram read
  // ------------------------------------------------------------------
  logic          accept;
  logic [31:0]   label_u;
  logic          label_ok;
  logic [AW-1:0] rd_addr;

  assign accept   = start && !busy;
  assign label_u  = 32'(unsigned'(atom_label[LABEL_W-2:0]));
  // negative labels, labels past atoms_in_use and past the table are dropped
  assign label_ok = !atom_label[LABEL_W-1]
                    && (label_u < 32'(atoms_in_use))
                    && (label_u < 32'(MAX_ATOMS));
  assign rd_addr  = label_u[AW-1:0];

  // ------------------------------------------------------------------
  // share table
  // ------------------------------------------------------------------
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  lvsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ATOMS)
  ) u_share_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // modify stage
  // ------------------------------------------------------------------
  logic                       s1_busy;
  logic                       s1_func;
  logic                       s1_ok;
  logic [AW-1:0]              s1_addr;
  logic signed [ENERGY_W-1:0] s1_energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_busy <= 1'b0;
    end else begin
      s1_busy <= accept;
    end
    s1_func   <= func;
    s1_ok     <= label_ok;
    s1_addr   <= rd_addr;
    s1_energy <= energy;
  end

  // last write, forwarded when the next item hits the same entry
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic [ENTRY_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= ram_we;
    end
    fwd_addr <= ram_waddr;
    fwd_data <= ram_wdata;
  end

  logic [ENTRY_W-1:0]          cur;
  logic [COUNT_BITS-1:0]       cur_cnt;
  logic [COUNT_BITS-1:0]       cur_void;
  logic signed [BIND_W-1:0]    cur_bind;
  logic signed [ENERGY_W-1:0]  cur_deep;
  logic [COUNT_BITS-1:0]       new_cnt;
  logic [COUNT_BITS-1:0]       new_void;
  logic signed [BIND_W-1:0]    new_bind;
  logic signed [ENERGY_W-1:0]  new_deep;
  logic signed [BIND_W:0]      bind_sum;
  logic                        e_neg;
  logic [CNT_X_W-1:0]          cnt_x;
  logic [CNT_X_W-1:0]          void_x;

  assign cur      = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
  assign cur_cnt  = cur[COUNT_BITS-1:0];
  assign cur_void = cur[VOID_LO +: COUNT_BITS];
  assign cur_bind = cur[BIND_LO +: BIND_W];
  assign cur_deep = cur[DEEP_LO +: ENERGY_W];
  assign e_neg    = s1_energy[ENERGY_W-1];

  always_comb begin
    // saturating counters
    new_cnt  = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
    new_void = cur_void;
    if (s1_energy < iso_level && !(&cur_void)) begin
      new_void = cur_void + 1'b1;
    end
    // binding sum adds negative energies only and clamps at its floor
    bind_sum = (BIND_W + 1)'(cur_bind) + (BIND_W + 1)'(s1_energy);
    new_bind = cur_bind;
    if (e_neg) begin
      if (bind_sum < (BIND_W + 1)'(BIND_MIN)) begin
        new_bind = BIND_MIN;
      end else begin
        new_bind = bind_sum[BIND_W-1:0];
      end
    end
    new_deep = (s1_energy < cur_deep) ? s1_energy : cur_deep;
  end

  assign cnt_x  = CNT_X_W'(cur_cnt);
  assign void_x = CNT_X_W'(cur_void);

  // write port: sweep zeros, accumulate, or clear on a read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr;
    ram_wdata = '0;
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (s1_busy && s1_ok) begin
      ram_we = 1'b1;
      if (s1_func == FUNC_ACCUM) begin
        ram_wdata = {new_deep, new_bind, new_void, new_cnt};
      end
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= s1_busy && (s1_func == FUNC_READ);
    end
    share_valid    <= s1_ok;
    voxel_count    <= s1_ok ? cnt_x[OUT_CNT_W-1:0] : '0;
    void_count     <= s1_ok ? void_x[OUT_CNT_W-1:0] : '0;
    binding_sum    <= s1_ok ? cur_bind : '0;
    deepest_energy <= s1_ok ? cur_deep : '0;
  end

endmodule

// ----- hw/rtl/lvsa_ram.sv -----
// generic single-port-write, registered-read ram
module lvsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
